FILE: sv/stel_pkg.sv
package stel_pkg;

  // list geometry and field widths
  localparam int unsigned LIST_DEPTH = 32;
  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned TAG_BITS   = 16;

  // count holds 0..LIST_DEPTH, index addresses one entry
  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(LIST_DEPTH);

  // result status codes
  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_FIRED = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  // commands from controller to datapath
  typedef struct packed {
    logic    capture_add;
    logic    capture_exec;
    logic    shift_step;
    logic    insert;
    logic    scan_step;
    logic    scan_done;
    logic    emit_start;
    logic    emit_load;
    logic    resp_load;
    status_e resp_status;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic shift_go;
    logic scan_go;
    logic scan_none;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/stel_ctrl.sv
module stel_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           mode_i,
  input  stel_pkg::sts_t sts_i,
  output stel_pkg::cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_SHIFT      = 8'b0000_0010,
    S_RESP_ADD   = 8'b0000_0100,
    S_RESP_FULL  = 8'b0000_1000,
    S_SCAN       = 8'b0001_0000,
    S_RESP_NONE  = 8'b0010_0000,
    S_EMIT_FETCH = 8'b0100_0000,
    S_EMIT_LOAD  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (mode_i) begin
            cmd_o.capture_exec = 1'b1;
            state_d            = S_SCAN;
          end else if (sts_i.full) begin
            state_d = S_RESP_FULL;
          end else begin
            cmd_o.capture_add = 1'b1;
            state_d           = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_go) begin
          cmd_o.shift_step = 1'b1;
        end else begin
          cmd_o.insert = 1'b1;
          state_d      = S_RESP_ADD;
        end
      end
      S_RESP_ADD: begin
        if (sts_i.out_free) begin
          cmd_o.resp_load   = 1'b1;
          cmd_o.resp_status = stel_pkg::ST_ADDED;
          state_d           = S_IDLE;
        end
      end
      S_RESP_FULL: begin
        if (sts_i.out_free) begin
          cmd_o.resp_load   = 1'b1;
          cmd_o.resp_status = stel_pkg::ST_FULL;
          state_d           = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_go) begin
          cmd_o.scan_step = 1'b1;
        end else begin
          cmd_o.scan_done = 1'b1;
          state_d         = sts_i.scan_none ? S_RESP_NONE : S_EMIT_FETCH;
        end
      end
      S_RESP_NONE: begin
        if (sts_i.out_free) begin
          cmd_o.resp_load   = 1'b1;
          cmd_o.resp_status = stel_pkg::ST_NONE;
          state_d           = S_IDLE;
        end
      end
      S_EMIT_FETCH: begin
        cmd_o.emit_start = 1'b1;
        state_d          = S_EMIT_LOAD;
      end
      S_EMIT_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/stel_datapath.sv
module stel_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  stel_pkg::cmd_t                  cmd_i,
  output stel_pkg::sts_t                  sts_o,
  input  logic [stel_pkg::TIME_BITS-1:0]  event_time_i,
  input  logic [stel_pkg::TAG_BITS-1:0]   event_tag_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [1:0]                      status_o,
  output logic [stel_pkg::TAG_BITS-1:0]   fired_tag_o,
  output logic [stel_pkg::TIME_BITS-1:0]  fired_time_o,
  output logic [stel_pkg::TIME_BITS-1:0]  next_time_o,
  output logic [stel_pkg::CNT_W-1:0]      pending_count_o,
  output logic                            last_o
);

  localparam int unsigned TW = stel_pkg::TIME_BITS;
  localparam int unsigned GW = stel_pkg::TAG_BITS;
  localparam int unsigned CW = stel_pkg::CNT_W;
  localparam int unsigned IW = stel_pkg::IDX_W;

  // event storage
  logic [TW-1:0] time_mem [stel_pkg::LIST_DEPTH];
  logic [GW-1:0] tag_mem  [stel_pkg::LIST_DEPTH];
  logic [TW-1:0] rd_time_q;
  logic [GW-1:0] rd_tag_q;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic          wr_en;
  logic [TW-1:0] wr_time;
  logic [GW-1:0] wr_tag;

  // list state
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ri_q, ri_d;
  logic [TW-1:0] nft_q, nft_d;
  logic [TW-1:0] head_q;

  // walk pointer and captured item
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] first_q, first_d;
  logic          mode_q, mode_d;
  logic [TW-1:0] t_q;
  logic [GW-1:0] g_q;

  // output register
  logic                  out_valid_q, out_valid_d;
  stel_pkg::status_e     out_status_q;
  logic [GW-1:0]         out_tag_q;
  logic [TW-1:0]         out_time_q;
  logic [TW-1:0]         out_next_q;
  logic [CW-1:0]         out_pend_q;
  logic                  out_last_q;

  // pointer steering
  always_comb begin
    ptr_d   = ptr_q;
    first_d = first_q;
    mode_d  = mode_q;
    if (cmd_i.capture_add) begin
      ptr_d  = count_q;
      mode_d = 1'b0;
    end
    if (cmd_i.capture_exec) begin
      ptr_d   = ri_q;
      first_d = ri_q;
      mode_d  = 1'b1;
    end
    if (cmd_i.shift_step) begin
      ptr_d = ptr_q - CW'(1);
    end
    if (cmd_i.scan_step || cmd_i.emit_load) begin
      ptr_d = ptr_q + CW'(1);
    end
    if (cmd_i.emit_start) begin
      ptr_d = first_q;
    end
  end

  // insertion reads the entry below the hole, scan and emit read at the pointer
  assign rd_addr = mode_d ? ptr_d[IW-1:0] : ptr_d[IW-1:0] - IW'(1);

  // memory write: shift an entry up or drop the new item into the hole
  assign wr_en   = cmd_i.shift_step | cmd_i.insert;
  assign wr_addr = ptr_q[IW-1:0];
  assign wr_time = cmd_i.shift_step ? rd_time_q : t_q;
  assign wr_tag  = cmd_i.shift_step ? rd_tag_q  : g_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      time_mem[wr_addr] <= wr_time;
      tag_mem[wr_addr]  <= wr_tag;
    end
    rd_time_q <= time_mem[rd_addr];
    rd_tag_q  <= tag_mem[rd_addr];
  end

  // list state update
  always_comb begin
    count_d = count_q;
    ri_d    = ri_q;
    nft_d   = nft_q;
    if (cmd_i.insert) begin
      count_d = count_q + CW'(1);
      nft_d   = (ptr_q == '0) ? t_q : head_q;
    end
    if (cmd_i.scan_done) begin
      ri_d  = ptr_q;
      nft_d = (ptr_q < count_q) ? rd_time_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ri_q        <= '0;
      nft_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ri_q        <= ri_d;
      nft_q       <= nft_d;
      out_valid_q <= out_valid_d;
    end
  end

  // walk registers and captured item
  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    first_q <= first_d;
    mode_q  <= mode_d;
    if (cmd_i.capture_add) begin
      t_q <= event_time_i;
      g_q <= event_tag_i;
    end
    if (cmd_i.insert && (ptr_q == '0)) begin
      head_q <= t_q;
    end
  end

  // output item register
  assign out_valid_d = (cmd_i.emit_load | cmd_i.resp_load) ? 1'b1 :
                       (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_status_q <= stel_pkg::ST_FIRED;
      out_tag_q    <= rd_tag_q;
      out_time_q   <= rd_time_q;
      out_last_q   <= sts_o.emit_last;
      out_next_q   <= nft_q;
      out_pend_q   <= count_q - ri_q;
    end else if (cmd_i.resp_load) begin
      out_status_q <= cmd_i.resp_status;
      out_tag_q    <= '0;
      out_time_q   <= '0;
      out_last_q   <= 1'b1;
      out_next_q   <= nft_q;
      out_pend_q   <= count_q - ri_q;
    end
  end

  // status to controller
  assign sts_o.full      = (count_q == CW'(stel_pkg::LIST_DEPTH));
  assign sts_o.shift_go  = (ptr_q != '0) && (rd_time_q >= t_q);
  assign sts_o.scan_go   = (ptr_q < count_q) && (rd_time_q == nft_q);
  assign sts_o.scan_none = (ptr_q == first_q);
  assign sts_o.emit_last = ((ptr_q + CW'(1)) == ri_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign fired_tag_o     = out_tag_q;
  assign fired_time_o    = out_time_q;
  assign next_time_o     = out_next_q;
  assign pending_count_o = out_pend_q;
  assign last_o          = out_last_q;

endmodule

FILE: sv/sorted_timed_event_list_core.sv
// add: one result, after the entries at or above the new time shift up; no shift when full
// execute: a scan over the due entries, one fetch state, then one fired
//   item per cycle while the output is free; one item with status 3 when nothing is due
// one item at a time; the next item is accepted once the last result is in the output register
// the shift and the scan walk the list memory one entry a cycle, with no stall
// reset: asynchronous active low, clears count, read index, next-fire time and output valid
module sorted_timed_event_list_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic [stel_pkg::TIME_BITS-1:0]  event_time_i,
  input  logic [stel_pkg::TAG_BITS-1:0]   event_tag_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      status_o,
  output logic [stel_pkg::TAG_BITS-1:0]   fired_tag_o,
  output logic [stel_pkg::TIME_BITS-1:0]  fired_time_o,
  output logic [stel_pkg::TIME_BITS-1:0]  next_time_o,
  output logic [stel_pkg::CNT_W-1:0]      pending_count_o,
  output logic                            last_o
);

  stel_pkg::cmd_t cmd;
  stel_pkg::sts_t sts;

  // sequencer
  stel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // list storage and output register
  stel_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .event_time_i    (event_time_i),
    .event_tag_i     (event_tag_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .fired_tag_o     (fired_tag_o),
    .fired_time_o    (fired_time_o),
    .next_time_o     (next_time_o),
    .pending_count_o (pending_count_o),
    .last_o          (last_o)
  );

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;

  // widths taken from the package
  localparam int unsigned TIME_BITS  = stel_pkg::TIME_BITS;
  localparam int unsigned TAG_BITS   = stel_pkg::TAG_BITS;
  localparam int unsigned CNT_W      = stel_pkg::CNT_W;
  localparam int unsigned LIST_DEPTH = stel_pkg::LIST_DEPTH;

  // item codes on mode_i
  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_EXEC = 1'b1;

  localparam int RAND_ITEMS  = 455;
  localparam int HOLD_AT     = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 80;
  localparam int CYCLE_LIMIT = 300000;

  // one input item, plus a flag that makes the sender wait until all results are in
  typedef struct packed {
    logic                 mode;
    logic [TIME_BITS-1:0] ev_t;
    logic [TAG_BITS-1:0]  ev_g;
    logic                 wait_idle;
  } list_op_t;

  // one result item
  typedef struct packed {
    stel_pkg::status_e    status;
    logic [TAG_BITS-1:0]  tag;
    logic [TIME_BITS-1:0] fired_t;
    logic [TIME_BITS-1:0] next_t;
    logic [CNT_W-1:0]     pend;
    logic                 last;
  } list_result_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic                 mode_i       = MODE_ADD;
  logic [TIME_BITS-1:0] event_time_i = '0;
  logic [TAG_BITS-1:0]  event_tag_i  = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [1:0]           status_o;
  logic [TAG_BITS-1:0]  fired_tag_o;
  logic [TIME_BITS-1:0] fired_time_o;
  logic [TIME_BITS-1:0] next_time_o;
  logic [CNT_W-1:0]     pending_count_o;
  logic                 last_o;

  sorted_timed_event_list_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .event_time_i    (event_time_i),
    .event_tag_i     (event_tag_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .fired_tag_o     (fired_tag_o),
    .fired_time_o    (fired_time_o),
    .next_time_o     (next_time_o),
    .pending_count_o (pending_count_o),
    .last_o          (last_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the event list
  logic [TIME_BITS-1:0] ev_time [LIST_DEPTH];
  logic [TAG_BITS-1:0]  ev_tag  [LIST_DEPTH];
  int                   ev_count  = 0;
  int                   rd_idx    = 0;
  logic [TIME_BITS-1:0] fire_time = '0;

  list_op_t     op_queue[$];
  list_result_t awaited_results[$];
  list_op_t     cur_op;
  list_result_t want;
  int           total_items = 0;
  int           sent_cnt    = 0;
  int           res_cnt     = 0;
  int           err_cnt     = 0;
  int           cycles      = 0;
  int           hold_left   = 0;
  bit           hold_done   = 1'b0;

  // build one result of the current list state
  function automatic list_result_t make_result(stel_pkg::status_e st,
                                               logic [TAG_BITS-1:0] g,
                                               logic [TIME_BITS-1:0] t, logic lst);
    list_result_t r;
    r.status  = st;
    r.tag     = g;
    r.fired_t = t;
    r.next_t  = fire_time;
    r.pend    = CNT_W'(ev_count - rd_idx);
    r.last    = lst;
    return r;
  endfunction

  // sorted insert or firing of due events, queueing the results they cause
  task automatic apply_list_op(input list_op_t op);
    int pos;
    int first;
    int nfired;
    int i;
    if (op.mode == MODE_ADD) begin
      if (ev_count >= LIST_DEPTH) begin
        awaited_results.push_back(make_result(stel_pkg::ST_FULL, '0, '0, 1'b1));
      end else begin
        pos = 0;
        while (pos < ev_count && op.ev_t > ev_time[pos]) pos++;
        for (i = ev_count; i > pos; i--) begin
          ev_time[i] = ev_time[i-1];
          ev_tag[i]  = ev_tag[i-1];
        end
        ev_time[pos] = op.ev_t;
        ev_tag[pos]  = op.ev_g;
        ev_count++;
        fire_time = ev_time[0];
        awaited_results.push_back(make_result(stel_pkg::ST_ADDED, '0, '0, 1'b1));
      end
    end else begin
      first = rd_idx;
      while (rd_idx < ev_count && rd_idx < LIST_DEPTH && ev_time[rd_idx] == fire_time)
        rd_idx++;
      nfired = rd_idx - first;
      if (rd_idx < ev_count && rd_idx < LIST_DEPTH) fire_time = ev_time[rd_idx];
      else fire_time = '0;
      if (nfired == 0) begin
        awaited_results.push_back(make_result(stel_pkg::ST_NONE, '0, '0, 1'b1));
      end else begin
        for (i = 0; i < nfired; i++)
          awaited_results.push_back(make_result(stel_pkg::ST_FIRED, ev_tag[first+i],
                                                ev_time[first+i], i + 1 == nfired));
      end
    end
  endtask

  task automatic push_op(input logic m, input logic [TIME_BITS-1:0] t,
                         input logic [TAG_BITS-1:0] g, input logic w);
    list_op_t op;
    op.mode      = m;
    op.ev_t      = t;
    op.ev_g      = g;
    op.wait_idle = w;
    op_queue.push_back(op);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_v);
    $display("tb_top: result %0d %s: got %0h, want %0h", res_cnt, what, got, exp_v);
    err_cnt++;
  endtask

  // idle percentage per side, by stimulus phase
  function automatic int idle_pct(input bit sender);
    if (sent_cnt < total_items / 3) return sender ? 9 : 60;
    if (sent_cnt < 2 * total_items / 3) return sender ? 60 : 9;
    return 0;
  endfunction

  // driver: offers queued items, updates the shadow list on each accepted item
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        apply_list_op(cur_op);
        sent_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (op_queue.size() != 0 &&
            !(op_queue[0].wait_idle && awaited_results.size() != 0) &&
            $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          cur_op = op_queue.pop_front();
          in_valid_i   <= 1'b1;
          mode_i       <= cur_op.mode;
          event_time_i <= cur_op.ev_t;
          event_tag_i  <= cur_op.ev_g;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted result, drives ready with idling and one long hold
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected, status", 32'(status_o), '0);
        end else begin
          want = awaited_results.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", 32'(status_o), 32'(want.status));
          if (fired_tag_o !== want.tag)
            report_mismatch("fired_tag", 32'(fired_tag_o), 32'(want.tag));
          if (fired_time_o !== want.fired_t)
            report_mismatch("fired_time", fired_time_o, want.fired_t);
          if (next_time_o !== want.next_t)
            report_mismatch("next_time", next_time_o, want.next_t);
          if (pending_count_o !== want.pend)
            report_mismatch("pending_count", 32'(pending_count_o), 32'(want.pend));
          if (last_o !== want.last) report_mismatch("last", 32'(last_o), 32'(want.last));
        end
        res_cnt++;
      end
      if (!hold_done && sent_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= idle_pct(1'b0));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int n;
    int kind;
    int burst;
    int b;
    logic [TIME_BITS-1:0] t;

    // directed: empty list, equal times, extremes, insert below the read index
    push_op(MODE_EXEC, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);  // nothing pending
    push_op(MODE_ADD,  32'd100,       16'h0001, 1'b0);
    push_op(MODE_ADD,  32'd100,       16'h0002, 1'b0);  // equal time goes in front
    push_op(MODE_ADD,  32'd50,        16'hFFFF, 1'b0);
    push_op(MODE_ADD,  32'hFFFF_FFFF, 16'h0000, 1'b0);
    push_op(MODE_EXEC, 32'h0,         16'h0,    1'b0);  // fires 50
    push_op(MODE_EXEC, 32'h0,         16'h0,    1'b0);  // fires both at 100
    push_op(MODE_ADD,  32'h0,         16'h00AA, 1'b0);  // lands in the fired region
    push_op(MODE_EXEC, 32'h0,         16'h0,    1'b0);  // nothing due, moves on
    push_op(MODE_EXEC, 32'h0,         16'h0,    1'b0);  // shifted entry fires again
    push_op(MODE_EXEC, 32'h0,         16'h0,    1'b0);  // fires the max time
    push_op(MODE_EXEC, 32'h0,         16'h0,    1'b0);  // list exhausted
    push_op(MODE_ADD,  32'h8000_0000, 16'h5555, 1'b0);
    push_op(MODE_ADD,  32'h7FFF_FFFF, 16'hAAAA, 1'b0);
    push_op(MODE_ADD,  32'h7FFF_FFFF, 16'h1234, 1'b0);
    push_op(MODE_EXEC, 32'h5555_5555, 16'h5555, 1'b0);  // add after firing, stale next time
    push_op(MODE_EXEC, 32'hAAAA_AAAA, 16'hAAAA, 1'b0);
    push_op(MODE_EXEC, 32'h0,         16'h0,    1'b0);

    // random: mostly lone executes with noise fields, sometimes a burst of adds then execute
    n = 0;
    while (n < RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        burst = $urandom_range(1, 4);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: t = TIME_BITS'($urandom_range(0, 7));
          5, 6, 7:       t = TIME_BITS'($urandom);
          8:             t = '0;
          default:       t = '1;
        endcase
        for (b = 0; b < burst; b++) begin
          push_op(MODE_ADD, ($urandom_range(0, 3) == 0) ? TIME_BITS'($urandom) : t,
                  TAG_BITS'($urandom), n == 0 || n == RAND_ITEMS / 2);
          n++;
        end
      end
      push_op(MODE_EXEC, TIME_BITS'($urandom), TAG_BITS'($urandom),
              n == 0 || n == RAND_ITEMS / 2);
      n++;
    end
    total_items = op_queue.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(sent_cnt == total_items && awaited_results.size() == 0)) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
